>>> rtl/core/ipshh_pkg.sv
// ----------------------------------------------------------------------------
// ipshh_pkg: shared record type for the subnet/host hit ranker
// Holds the queued transaction format passed between front and back.
// ----------------------------------------------------------------------------
package ipshh_pkg;

    typedef struct packed {
        logic [15:0] net_key;
        logic [15:0] host_lo;
        logic        eol;
    } t_rec;

endpackage

>>> rtl/core/ip_subnet_host_hit_ranker.sv
// ----------------------------------------------------------------------------
// ip_subnet_host_hit_ranker: IPv4 network and host hit ranker
// Counts hits per network and host, reports the busiest at end of log.
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// input     in         i_valid/o_stall   i_addr_octet_a..d, i_end_of_log
// result    out        o_valid/i_stall   o_entry_kind .. o_last_result
//
// A record is searched in the network table and then the host table, one
// table entry per cycle, and then counted. At end of log the back end scans
// for the busiest network and reports every network at that count, then
// does the same for hosts. A stalled result holds the back end, and the
// input stalls once the two-entry queue is full. Synchronous active-low
// reset empties the tables at once.
// ----------------------------------------------------------------------------
module ip_subnet_host_hit_ranker
    import ipshh_pkg::*;
#(
    parameter int NETWORK_ENTRIES = 16,
    parameter int HOST_ENTRIES    = 32,
    parameter int COUNT_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_addr_octet_a,
    input  logic [7:0]  i_addr_octet_b,
    input  logic [7:0]  i_addr_octet_c,
    input  logic [7:0]  i_addr_octet_d,
    input  logic        i_end_of_log,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_entry_kind,
    output logic [7:0]  o_out_octet_a,
    output logic [7:0]  o_out_octet_b,
    output logic [7:0]  o_out_octet_c,
    output logic [7:0]  o_out_octet_d,
    output logic [15:0] o_hit_count,
    output logic        o_table_overflowed,
    output logic        o_last_result
);
    logic w_qv, w_pop;
    t_rec w_rec;

    ipshh_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_addr_octet_a, .i_addr_octet_b, .i_addr_octet_c, .i_addr_octet_d,
        .i_end_of_log,
        .o_q_valid(w_qv), .o_q_rec(w_rec), .i_q_pop(w_pop)
    );

    ipshh_back #(
        .NETWORK_ENTRIES(NETWORK_ENTRIES),
        .HOST_ENTRIES(HOST_ENTRIES),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_qv), .i_q_rec(w_rec), .o_q_pop(w_pop),
        .o_valid, .i_stall, .o_entry_kind,
        .o_out_octet_a, .o_out_octet_b, .o_out_octet_c, .o_out_octet_d,
        .o_hit_count, .o_table_overflowed, .o_last_result
    );
endmodule

>>> rtl/core/ipshh_front.sv
// ----------------------------------------------------------------------------
// ipshh_front: input stage and record queue
// Accepts transactions, packs the key fields and queues them for the back end.
// ----------------------------------------------------------------------------
module ipshh_front
    import ipshh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_addr_octet_a,
    input  logic [7:0]  i_addr_octet_b,
    input  logic [7:0]  i_addr_octet_c,
    input  logic [7:0]  i_addr_octet_d,
    input  logic        i_end_of_log,
    output logic        o_q_valid,
    output t_rec        o_q_rec,
    input  logic        i_q_pop
);
    t_rec       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    logic       w_push;

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_rec   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !(i_q_pop && o_q_valid)) n_cnt = r_cnt + 2'd1;
        else if (!w_push && i_q_pop && o_q_valid) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= !r_wp;
            if (i_q_pop && o_q_valid) r_rp <= !r_rp;
        end
        if (w_push) begin
            r_q[r_wp] <= '{net_key: {i_addr_octet_a, i_addr_octet_b},
                           host_lo: {i_addr_octet_c, i_addr_octet_d},
                           eol:     i_end_of_log};
        end
    end
endmodule

>>> rtl/core/ipshh_back.sv
// ----------------------------------------------------------------------------
// ipshh_back: table search, counting and report sequencer
// Scans tables one entry per cycle, counts hits and emits the ranked report.
// ----------------------------------------------------------------------------
module ipshh_back
    import ipshh_pkg::*;
#(
    parameter int NETWORK_ENTRIES = 16,
    parameter int HOST_ENTRIES    = 32,
    parameter int COUNT_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_rec        i_q_rec,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_entry_kind,
    output logic [7:0]  o_out_octet_a,
    output logic [7:0]  o_out_octet_b,
    output logic [7:0]  o_out_octet_c,
    output logic [7:0]  o_out_octet_d,
    output logic [15:0] o_hit_count,
    output logic        o_table_overflowed,
    output logic        o_last_result
);
    localparam int NW = $clog2(NETWORK_ENTRIES);
    localparam int HW = $clog2(HOST_ENTRIES);
    localparam int NC = $clog2(NETWORK_ENTRIES + 1);
    localparam int HC = $clog2(HOST_ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [3:0] S_IDLE  = 4'd0, S_NSRCH = 4'd1, S_HSRCH = 4'd2,
                           S_UPD   = 4'd3, S_NMAX  = 4'd4, S_HMAX  = 4'd5,
                           S_NRPT  = 4'd6, S_HRPT  = 4'd7, S_EMIT  = 4'd8,
                           S_HRD   = 4'd9;

    logic [15:0]           r_nkey [NETWORK_ENTRIES];
    logic [COUNT_BITS-1:0] r_ncnt [NETWORK_ENTRIES];
    logic [NW-1:0]         r_hnet [HOST_ENTRIES];
    logic [15:0]           r_hlo  [HOST_ENTRIES];
    logic [COUNT_BITS-1:0] r_hcnt [HOST_ENTRIES];

    logic [3:0]            r_st, r_ret;
    logic [NC-1:0]         r_nused;
    logic [HC-1:0]         r_hused;
    logic                  r_ovf;
    t_rec                  r_rec;
    logic [NC-1:0]         r_ni;
    logic [HC-1:0]         r_hi;
    logic                  r_nnew, r_hnew;
    logic [COUNT_BITS-1:0] r_best;
    logic [NC-1:0]         r_n;
    logic [HC-1:0]         r_i;

    // pending result held until the next one is found, so the last one can be marked
    logic                  r_pv;
    logic                  r_pkind;
    logic [31:0]           r_paddr;

    // held candidate result
    logic                  r_hkind_q;
    logic [31:0]           r_haddr_q;
    logic [15:0]           r_hbest_q;

    logic [15:0]           w_cnt16;
    logic                  w_nfull, w_hfull;

    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;
    assign w_cnt16 = (COUNT_BITS > 16 && r_best > COUNT_BITS'(16'hFFFF)) ?
                     16'hFFFF : 16'(r_best);
    assign w_nfull = (r_nused == NC'(NETWORK_ENTRIES));
    assign w_hfull = (r_hused == HC'(HOST_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_nused <= '0;
            r_hused <= '0;
            r_ovf   <= 1'b0;
            r_pv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // the emit state drives o_valid itself whenever the output is free
            if (o_valid && !i_stall && r_st != S_EMIT) o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_rec  <= i_q_rec;
                        r_ni   <= '0;
                        r_nnew <= 1'b1;
                        r_st   <= S_NSRCH;
                    end
                end
                S_NSRCH: begin
                    if (r_ni == r_nused) begin
                        if (w_nfull) begin
                            r_ovf <= 1'b1;
                            r_st  <= S_NMAX;
                        end else begin
                            r_hi   <= r_hused;
                            r_hnew <= 1'b1;
                            r_st   <= S_HSRCH;
                        end
                    end else if (r_nkey[r_ni[NW-1:0]] == r_rec.net_key) begin
                        r_nnew <= 1'b0;
                        r_hi   <= '0;
                        r_hnew <= 1'b1;
                        r_st   <= S_HSRCH;
                    end else begin
                        r_ni <= r_ni + NC'(1);
                    end
                end
                S_HSRCH: begin
                    if (r_nnew || r_hi == r_hused) begin
                        if (w_hfull) begin
                            r_ovf <= 1'b1;
                            r_st  <= S_NMAX;
                        end else begin
                            r_hi <= r_hused;
                            r_st <= S_UPD;
                        end
                    end else if (r_hnet[r_hi[HW-1:0]] == r_ni[NW-1:0]
                                 && r_hlo[r_hi[HW-1:0]] == r_rec.host_lo) begin
                        r_hnew <= 1'b0;
                        r_st   <= S_UPD;
                    end else begin
                        r_hi <= r_hi + HC'(1);
                    end
                end
                S_UPD: begin
                    if (r_nnew) begin
                        r_nkey[r_ni[NW-1:0]] <= r_rec.net_key;
                        r_ncnt[r_ni[NW-1:0]] <= COUNT_BITS'(1);
                        r_nused <= r_nused + NC'(1);
                    end else if (r_ncnt[r_ni[NW-1:0]] != CMAX) begin
                        r_ncnt[r_ni[NW-1:0]] <= r_ncnt[r_ni[NW-1:0]] + COUNT_BITS'(1);
                    end
                    if (r_hnew) begin
                        r_hnet[r_hi[HW-1:0]] <= r_ni[NW-1:0];
                        r_hlo[r_hi[HW-1:0]]  <= r_rec.host_lo;
                        r_hcnt[r_hi[HW-1:0]] <= COUNT_BITS'(1);
                        r_hused <= r_hused + HC'(1);
                    end else if (r_hcnt[r_hi[HW-1:0]] != CMAX) begin
                        r_hcnt[r_hi[HW-1:0]] <= r_hcnt[r_hi[HW-1:0]] + COUNT_BITS'(1);
                    end
                    r_st <= S_NMAX;
                end
                S_NMAX: begin
                    // entered from count or drop; only the end of a log reports
                    if (!r_rec.eol) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_best <= '0;
                        r_n    <= '0;
                        r_st   <= S_HMAX;
                        r_ret  <= S_NMAX;
                    end
                end
                S_HMAX: begin
                    // r_ret tells which table's max scan this is
                    if (r_ret == S_NMAX) begin
                        if (r_n == r_nused) begin
                            r_n  <= '0;
                            r_st <= S_NRPT;
                        end else begin
                            if (r_ncnt[r_n[NW-1:0]] > r_best) r_best <= r_ncnt[r_n[NW-1:0]];
                            r_n <= r_n + NC'(1);
                        end
                    end else begin
                        if (r_i == r_hused) begin
                            r_n  <= '0;
                            r_i  <= '0;
                            r_st <= S_HRPT;
                        end else begin
                            if (r_hcnt[r_i[HW-1:0]] > r_best) r_best <= r_hcnt[r_i[HW-1:0]];
                            r_i <= r_i + HC'(1);
                        end
                    end
                end
                S_NRPT: begin
                    if (r_n == r_nused) begin
                        r_best <= '0;
                        r_i    <= '0;
                        r_ret  <= S_HMAX;
                        r_st   <= S_HMAX;
                    end else begin
                        if (r_ncnt[r_n[NW-1:0]] == r_best) begin
                            r_pkind <= 1'b0;
                            r_paddr <= {r_nkey[r_n[NW-1:0]], 16'h0};
                            r_ret   <= S_NRPT;
                            r_st    <= S_EMIT;
                        end
                        r_n <= r_n + NC'(1);
                    end
                end
                S_HRPT: begin
                    if (r_n == r_nused) begin
                        // flush the held result as the final one
                        if (r_pv) begin
                            r_ret <= S_HRD;
                            r_st  <= S_EMIT;
                        end else begin
                            r_nused <= '0;
                            r_hused <= '0;
                            r_st    <= S_IDLE;
                        end
                    end else if (r_i == r_hused) begin
                        r_i <= '0;
                        r_n <= r_n + NC'(1);
                    end else begin
                        if (r_hnet[r_i[HW-1:0]] == r_n[NW-1:0]
                            && r_hcnt[r_i[HW-1:0]] == r_best) begin
                            r_pkind <= 1'b1;
                            r_paddr <= {r_nkey[r_n[NW-1:0]], r_hlo[r_i[HW-1:0]]};
                            r_ret   <= S_HRPT;
                            r_st    <= S_EMIT;
                        end
                        r_i <= r_i + HC'(1);
                    end
                end
                S_EMIT: begin
                    // r_pkind/r_paddr hold the new candidate unless flushing
                    if (!o_valid || !i_stall) begin
                        if (r_ret == S_HRD) begin
                            o_valid       <= 1'b1;
                            o_last_result <= 1'b1;
                            r_pv          <= 1'b0;
                            r_nused       <= '0;
                            r_hused       <= '0;
                            r_st          <= S_IDLE;
                        end else begin
                            o_valid       <= r_pv;
                            o_last_result <= 1'b0;
                            r_pv          <= 1'b1;
                            r_st          <= r_ret;
                        end
                        if (r_ret != S_HRD) begin
                            o_entry_kind  <= r_hkind_q;
                            o_out_octet_a <= r_haddr_q[31:24];
                            o_out_octet_b <= r_haddr_q[23:16];
                            o_out_octet_c <= r_haddr_q[15:8];
                            o_out_octet_d <= r_haddr_q[7:0];
                            o_hit_count   <= r_hbest_q;
                            r_hkind_q     <= r_pkind;
                            r_haddr_q     <= r_paddr;
                            r_hbest_q     <= w_cnt16;
                        end else begin
                            o_entry_kind  <= r_hkind_q;
                            o_out_octet_a <= r_haddr_q[31:24];
                            o_out_octet_b <= r_haddr_q[23:16];
                            o_out_octet_c <= r_haddr_q[15:8];
                            o_out_octet_d <= r_haddr_q[7:0];
                            o_hit_count   <= r_hbest_q;
                        end
                        o_table_overflowed <= r_ovf;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
